// ===== design/trial_division_prime_test_unit_macros.svh =====
//------------------------------------------------------------------------------
// trial_division_prime_test_unit_macros.svh
// Assertion macros shared by the prime test design files
//------------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_UNIT_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock outside reset
`define TDP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define TDP_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TDP_ASSERT(lbl, prop, msg)
`define TDP_NEVER(lbl, cond, msg)
`endif

`endif

// ===== design/tdp_pkg.sv =====
//------------------------------------------------------------------------------
// tdp_pkg
// Types shared by the trial division prime test unit
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdp_pkg;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASSIFY,
        ST_BOUND,
        ST_DIVIDE,
        ST_FINISH
    } tdp_state_t;

    // status returned by the serial remainder unit
    typedef struct packed {
        logic done;
        logic rem_zero;
    } tdp_rem_status_t;

    // first trial divisor and its square
    localparam int unsigned FIRST_DIVISOR = 3;
    localparam int unsigned FIRST_SQUARE  = 9;

endpackage

// ===== design/tdp_rem.sv =====
//------------------------------------------------------------------------------
// tdp_rem
// Bit-serial restoring remainder unit, one dividend bit per cycle
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "trial_division_prime_test_unit_macros.svh"

module tdp_rem
    import tdp_pkg::*;
#(
    parameter int VALUE_WIDTH   = 32,
    parameter int DIVISOR_WIDTH = 17
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [VALUE_WIDTH-1:0]   dividend,
    input  logic [DIVISOR_WIDTH-1:0] divisor,
    output tdp_rem_status_t          status
);

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0]   sh_reg, sh_next;
    logic [DIVISOR_WIDTH-1:0] div_reg, div_next;
    logic [DIVISOR_WIDTH-1:0] r_reg, r_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DIVISOR_WIDTH:0]   r_shift;
    logic [DIVISOR_WIDTH:0]   r_diff;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    assign r_shift = {r_reg, sh_reg[VALUE_WIDTH-1]};
    assign r_diff  = r_shift - {1'b0, div_reg};

    always_comb
    begin
        sh_next   = sh_reg;
        div_next  = div_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            sh_next   = dividend;
            div_next  = divisor;
            r_next    = '0;
            cnt_next  = CW'(VALUE_WIDTH);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            sh_next  = {sh_reg[VALUE_WIDTH-2:0], 1'b0};
            r_next   = (r_shift >= {1'b0, div_reg}) ? r_diff[DIVISOR_WIDTH-1:0]
                                                    : r_shift[DIVISOR_WIDTH-1:0];
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        div_reg <= div_next;
        r_reg   <= r_next;
    end

    assign status.done     = done_reg;
    assign status.rem_zero = (r_reg == '0);

    `TDP_NEVER(a_start_busy, start && busy_reg, "start while a remainder is in progress")
    `TDP_ASSERT(a_done_pulse, done_reg |=> !done_reg, "done held longer than one cycle")
    `TDP_NEVER(a_rem_bound, busy_reg && (r_reg >= div_reg), "partial remainder not below divisor")

endmodule

// ===== design/trial_division_prime_test_unit.sv =====
//------------------------------------------------------------------------------
// trial_division_prime_test_unit
// Primality test of a signed integer by trial division with odd divisors
//------------------------------------------------------------------------------
// Usage:
//   s_tdata carries one signed value per word, m_tdata bit 0 returns is_prime.
//   One value is worked on at a time; s_tready is high while the sequencer
//   is idle, also while a finished result still sits in the output register.
//   Negative values, zero, one and even values resolve in ST_CLASSIFY.
//   An odd value tries divisors 3, 5, 7, ... while d*d <= value; each divisor
//   is tested by the bit-serial remainder unit, which brings down one dividend
//   bit per cycle. Composites stop at their first factor.
//   The square bound is kept incrementally: (d+2)^2 = d^2 + 4d + 4.
//   A result waits in the output register while m_tready is low; the
//   sequencer then holds its finished result and takes no new value until
//   the output register frees. Reset clears the sequencer and m_tvalid;
//   no clearing pass is needed.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "trial_division_prime_test_unit_macros.svh"

module trial_division_prime_test_unit
    import tdp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,   // value
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata    // is_prime
);

    localparam int DW = VALUE_WIDTH / 2 + 1;

    tdp_state_t             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] v_reg, v_next;
    logic [DW-1:0]          d_reg, d_next;
    logic [VALUE_WIDTH-1:0] sq_reg, sq_next;
    logic                   prime_reg, prime_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_prime_reg, out_prime_next;
    logic                   div_start;
    logic                   load;
    tdp_rem_status_t        rem_status;

    // serial remainder of the value by the current divisor
    tdp_rem #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .DIVISOR_WIDTH (DW)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (v_reg),
        .divisor  (d_reg),
        .status   (rem_status)
    );

    // sequencer: classify, then walk the odd divisors
    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        prime_next = prime_reg;
        div_start  = 1'b0;
        load       = 1'b0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    v_next     = s_tdata[VALUE_WIDTH-1:0];
                    state_next = ST_CLASSIFY;
                end
            end
            ST_CLASSIFY:
            begin
                d_next  = DW'(FIRST_DIVISOR);
                sq_next = VALUE_WIDTH'(FIRST_SQUARE);
                if (v_reg[VALUE_WIDTH-1] || (v_reg < VALUE_WIDTH'(2)))
                begin
                    prime_next = 1'b0;
                    state_next = ST_FINISH;
                end
                else if (!v_reg[0])
                begin
                    prime_next = (v_reg == VALUE_WIDTH'(2));
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                if (sq_reg > v_reg)
                begin
                    prime_next = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (rem_status.done)
                begin
                    if (rem_status.rem_zero)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        d_next     = d_reg + DW'(2);
                        sq_next    = sq_reg + (VALUE_WIDTH'(d_reg) << 2) + VALUE_WIDTH'(4);
                        state_next = ST_BOUND;
                    end
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            out_prime_next = prime_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        d_reg         <= d_next;
        sq_reg        <= sq_next;
        prime_reg     <= prime_next;
        out_prime_reg <= out_prime_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_prime_reg};

    `TDP_NEVER(a_load_blocked, load && out_valid_reg && !m_tready, "result overwrote a waiting word")
    `TDP_NEVER(a_even_divisor, (state_reg == ST_DIVIDE) && !d_reg[0], "trial divisor is even")
    `TDP_NEVER(a_bound_kept, (state_reg == ST_DIVIDE) && (sq_reg > v_reg), "dividing past the square bound")

endmodule
